// ----- src/bchd_pkg.sv -----
// shared types and constants of the button click / hold detector
// no dependencies; used by the state machine, the result queue, the top level and the checker
`default_nettype none

package bchd_pkg;

	// event codes carried in the result
	localparam logic [2:0] EV_PRESS        = 3'd0;
	localparam logic [2:0] EV_HOLD_START   = 3'd1;
	localparam logic [2:0] EV_ONE_CLICK    = 3'd2;
	localparam logic [2:0] EV_MULTI        = 3'd3;
	localparam logic [2:0] EV_HOLD_REPORT  = 3'd4;
	localparam logic [2:0] EV_HOLD_RELEASE = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_PRESS_DEBOUNCE   = 2'd0;
	localparam logic [1:0] REG_HOLD             = 2'd1;
	localparam logic [1:0] REG_RELEASE_DEBOUNCE = 2'd2;
	localparam logic [1:0] REG_MULTICLICK       = 2'd3;

	// hold time scaling, ticks to ms, and the largest tick count that does not overflow
	localparam int unsigned MS_PER_TICK  = 10;
	localparam logic [31:0] MS_SAT_LIMIT = 32'(32'hFFFF_FFFF / MS_PER_TICK);

	typedef struct packed {
		logic [15:0] press_debounce_ticks;
		logic [15:0] hold_ticks;
		logic [15:0] release_debounce_ticks;
		logic [15:0] multiclick_window_ticks;
	} bchd_cfg_t;

	typedef struct packed {
		logic [2:0]  event_code;
		logic [31:0] event_value;
		logic        last;
	} bchd_ev_t;

	// up to two events caused by one poll
	typedef struct packed {
		logic [1:0] count;
		bchd_ev_t   ev0;
		bchd_ev_t   ev1;
	} bchd_res_t;

endpackage

`default_nettype wire

// ----- src/bchd_fsm.sv -----
// debounce and click / hold state machine, one poll per request
// depends on bchd_pkg for the configuration and event types
`default_nettype none

module bchd_fsm #(
	parameter int TICK_WIDTH  = 32,
	parameter int COUNT_WIDTH = 8
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        step,
	input  wire                        pressed,
	input  wire  [31:0]                now_tick,
	input  bchd_pkg::bchd_cfg_t        cfg,
	output bchd_pkg::bchd_res_t        res
);
	import bchd_pkg::*;

	localparam logic [3:0] ST_IDLE        = 4'd0;
	localparam logic [3:0] ST_DEBOUNCE    = 4'd1;
	localparam logic [3:0] ST_PRESSED     = 4'd2;
	localparam logic [3:0] ST_WAIT_HOLD   = 4'd3;
	localparam logic [3:0] ST_RELEASE     = 4'd4;
	localparam logic [3:0] ST_CLICK       = 4'd5;
	localparam logic [3:0] ST_WAIT_MULTI  = 4'd6;
	localparam logic [3:0] ST_HOLD        = 4'd7;
	localparam logic [3:0] ST_HOLD_PASSED = 4'd8;

	logic [3:0]             state_q, state_d;
	logic [TICK_WIDTH-1:0]  to_start_q;
	logic [15:0]            to_len_q;
	logic                   to_run_q;
	logic [TICK_WIDTH-1:0]  hold_begin_q;
	logic [COUNT_WIDTH-1:0] click_cnt_q, click_cnt_d, click_inc;

	logic [TICK_WIDTH-1:0]  now_w;
	logic [TICK_WIDTH-1:0]  to_elapsed;
	logic                   expired;
	logic [TICK_WIDTH-1:0]  hold_elapsed;
	logic [63:0]            hold_el64;
	logic [31:0]            hold_ms;

	logic                   set_to;
	logic                   stop_to;
	logic                   set_hold;
	logic [15:0]            to_len_sel;

	// tick arithmetic modulo the tick width
	assign now_w        = TICK_WIDTH'(now_tick);
	assign to_elapsed   = now_w - to_start_q;
	assign expired      = !to_run_q || (to_elapsed >= TICK_WIDTH'(to_len_q));
	assign hold_elapsed = now_w - hold_begin_q;
	assign hold_el64    = 64'(hold_elapsed);
	assign hold_ms      = (hold_el64 > 64'(MS_SAT_LIMIT)) ? 32'hFFFF_FFFF
	                    : 32'(hold_el64[31:0] * MS_PER_TICK);

	// saturating click count
	assign click_inc = (click_cnt_q != {COUNT_WIDTH{1'b1}}) ? click_cnt_q + 1'b1 : click_cnt_q;

	// next state and events of one poll
	always_comb begin
		state_d     = state_q;
		click_cnt_d = click_cnt_q;
		set_to      = 1'b0;
		stop_to     = 1'b0;
		set_hold    = 1'b0;
		to_len_sel  = cfg.press_debounce_ticks;
		res         = '0;
		if (pressed) begin
			case (state_q)
				ST_IDLE: begin
					state_d  = ST_DEBOUNCE;
					set_to   = 1'b1;
					set_hold = 1'b1;
				end
				ST_DEBOUNCE: begin
					if (expired) state_d = ST_PRESSED;
				end
				ST_PRESSED: begin
					state_d    = ST_WAIT_HOLD;
					set_to     = 1'b1;
					to_len_sel = cfg.hold_ticks;
					res.count  = 2'd1;
					res.ev0    = '{event_code: EV_PRESS, event_value: 32'd0, last: 1'b1};
				end
				ST_WAIT_HOLD: begin
					if (expired) begin
						state_d   = ST_HOLD;
						res.count = 2'd1;
						res.ev0   = '{event_code: EV_HOLD_START, event_value: 32'd0, last: 1'b1};
					end
				end
				ST_WAIT_MULTI: begin
					// a new press inside the window restarts debouncing
					if (!expired) begin
						state_d  = ST_DEBOUNCE;
						set_to   = 1'b1;
						set_hold = 1'b1;
					end
				end
				ST_HOLD: begin
					res.count = 2'd1;
					res.ev0   = '{event_code: EV_HOLD_REPORT, event_value: hold_ms, last: 1'b1};
				end
				default: begin
				end
			endcase
		end else begin
			case (state_q)
				ST_WAIT_HOLD: begin
					state_d    = ST_RELEASE;
					set_to     = 1'b1;
					to_len_sel = cfg.release_debounce_ticks;
				end
				ST_RELEASE: begin
					if (expired) begin
						state_d     = ST_CLICK;
						click_cnt_d = click_inc;
						res.count   = 2'd2;
						res.ev0     = '{event_code: EV_ONE_CLICK, event_value: 32'd0, last: 1'b0};
						res.ev1     = '{event_code: EV_MULTI, event_value: 32'(click_inc),
						                last: 1'b1};
					end
				end
				ST_HOLD: begin
					state_d     = ST_HOLD_PASSED;
					stop_to     = 1'b1;
					click_cnt_d = '0;
					res.count   = 2'd1;
					res.ev0     = '{event_code: EV_HOLD_RELEASE, event_value: 32'd0, last: 1'b1};
				end
				ST_CLICK: begin
					state_d    = ST_WAIT_MULTI;
					set_to     = 1'b1;
					to_len_sel = cfg.multiclick_window_ticks;
				end
				ST_WAIT_MULTI: begin
					if (expired) begin
						state_d     = ST_IDLE;
						stop_to     = 1'b1;
						click_cnt_d = '0;
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// state registers, updated on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			to_start_q   <= '0;
			to_len_q     <= '0;
			to_run_q     <= 1'b0;
			hold_begin_q <= '0;
			click_cnt_q  <= '0;
		end else if (step) begin
			state_q     <= state_d;
			click_cnt_q <= click_cnt_d;
			if (set_to) begin
				to_start_q <= now_w;
				to_len_q   <= to_len_sel;
				to_run_q   <= 1'b1;
			end else if (stop_to) begin
				to_run_q <= 1'b0;
			end
			if (set_hold) hold_begin_q <= now_w;
		end
	end

endmodule

`default_nettype wire

// ----- src/bchd_resq.sv -----
// four-entry queue: takes up to two events per request, gives one per cycle on pop
// depends on bchd_pkg for the event types
`default_nettype none

module bchd_resq (
	input  wire                   clk,
	input  wire                   arst_n,
	input  bchd_pkg::bchd_res_t   res,
	input  wire                   push,
	input  wire                   pop,
	output logic                  room,
	output logic                  out_valid,
	output bchd_pkg::bchd_ev_t    out_ev
);
	import bchd_pkg::*;

	bchd_ev_t   slot_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic [1:0] push_n;
	logic [1:0] wr_ptr_nx;

	assign push_n    = push ? res.count : 2'd0;
	assign wr_ptr_nx = wr_ptr_q + 2'd1;
	assign room      = count_q <= 3'd2;
	assign out_valid = count_q != 3'd0;
	assign out_ev    = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) slot_q[wr_ptr_q] <= res.ev0;
		if (push_n == 2'd2) slot_q[wr_ptr_nx] <= res.ev1;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop && out_valid) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(push_n) - 3'(pop && out_valid);
		end
	end

endmodule

`default_nettype wire

// ----- src/button_click_hold_detector.sv -----
// button click / hold detector: one poll per cycle unless the slave side stalls
// results: a poll's results are registered in the result queue and offered from it
// throughput: one poll per cycle; a click gives two results, which leave one at a time,
// so the slave side stalls while the four-entry result queue has fewer than two free slots
// reset: state machine idle, timeout stopped, counts and queue cleared, registers to defaults
// depends on bchd_pkg, bchd_fsm and bchd_resq
`default_nettype none

module button_click_hold_detector #(
	parameter int TICK_WIDTH  = 32,
	parameter int COUNT_WIDTH = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// poll requests
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,   // pressed[0], now_tick[32:1], zero fill
	// results
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [39:0] m_tdata,   // event_code[2:0], event_value[34:3], zero fill
	output logic        m_tlast,
	// configuration writes
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_wdata
);
	import bchd_pkg::*;

	bchd_cfg_t cfg_q;
	bchd_res_t res;
	bchd_ev_t  out_ev;
	logic      step;

	assign step = s_tvalid && s_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_debounce_ticks    <= 16'd5;
			cfg_q.hold_ticks              <= 16'd100;
			cfg_q.release_debounce_ticks  <= 16'd5;
			cfg_q.multiclick_window_ticks <= 16'd30;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PRESS_DEBOUNCE:   cfg_q.press_debounce_ticks    <= cfg_wdata;
				REG_HOLD:             cfg_q.hold_ticks              <= cfg_wdata;
				REG_RELEASE_DEBOUNCE: cfg_q.release_debounce_ticks  <= cfg_wdata;
				REG_MULTICLICK:       cfg_q.multiclick_window_ticks <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// state machine
	bchd_fsm #(
		.TICK_WIDTH  (TICK_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.pressed  (s_tdata[0]),
		.now_tick (s_tdata[32:1]),
		.cfg      (cfg_q),
		.res      (res)
	);

	// result queue
	bchd_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.push      (step),
		.pop       (m_tready),
		.room      (s_tready),
		.out_valid (m_tvalid),
		.out_ev    (out_ev)
	);

	// result packing
	assign m_tdata = {5'd0, out_ev.event_value, out_ev.event_code};
	assign m_tlast = out_ev.last;

endmodule

`default_nettype wire

// ----- src/bchd_checker.sv -----
// port-level checks of the button click / hold detector, bound to the top level
// depends on bchd_pkg for the event codes
`default_nettype none

module bchd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        s_tready,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [39:0] m_tdata,
	input wire        m_tlast
);
	import bchd_pkg::*;

	logic [2:0]  code;
	logic [31:0] value;

	assign code  = m_tdata[2:0];
	assign value = m_tdata[34:3];

	// the slave side only stalls while results are waiting
	a_stall_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("request stalled with no result pending");

	// a stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// only the click count and the hold report carry a value
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && code != EV_MULTI && code != EV_HOLD_REPORT |-> value == 32'd0)
		else $error("non-zero value on an event without one");

	// a one-click result is always followed by its count, which closes the request
	a_click_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && code == EV_ONE_CLICK |=> m_tvalid && m_tdata[2:0] == EV_MULTI)
		else $error("click not followed by its count");

	// the last marker sits on every result but the one-click event
	a_last_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (code != EV_ONE_CLICK)))
		else $error("last marker on the wrong result");

endmodule

bind button_click_hold_detector bchd_checker u_bchd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
